// ===== rtl/fcst_pkg.sv =====
package fcst_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 7;
    localparam int CAP_W       = 7;
    localparam int RANK_W      = 6;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE    = 2'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;
    localparam logic [OP_W-1:0] OP_GET      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANK      = 3'd4;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

endpackage

// ===== rtl/fcst_ram.sv =====
module fcst_ram
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fixed_capacity_set_table_top.sv =====
// Fixed-capacity set table: up to 64 slots of 32-bit values, each with a valid bit, of which
// only the first "capacity" slots are used (a capacity write also empties the table). Every
// request (insert, erase, contains, get by rank) returns one result with ok, status, the
// value for a get, the entry count and an empty flag. One request is handled at a time: a
// request is transferred in, then every used slot is read in turn through the single read
// port of the value memory, one slot per cycle, and compared once its registered read data
// returns; after the last compare the scan ends and the result is committed to the output
// register. Valid bits live in flip-flops and are cleared by reset at once, so there is no
// clearing pass. The result sits in an output register, so the next request is taken while
// an earlier result still waits for its transfer.
module fixed_capacity_set_table_top
    import fcst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   capacity_wr_en,
    input  logic [CAP_W-1:0]       capacity,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OP_W-1:0]        opcode,
    input  logic [VALUE_WIDTH-1:0] item_value,
    input  logic [RANK_W-1:0]      slot_rank,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [STATUS_W-1:0]    status,
    output logic [VALUE_WIDTH-1:0] found_value,
    output logic [CNT_W-1:0]       item_count,
    output logic                   is_empty
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    cnt_t                   count_reg, count_next;
    cnt_t                   issue_cnt_reg, issue_cnt_next;
    logic                   cmp_act_reg, cmp_act_next;
    logic                   out_valid_reg, out_valid_next;

    // scan trackers
    logic                   hit_reg, hit_next;
    idx_t                   hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    idx_t                   free_idx_reg, free_idx_next;
    logic                   got_reg, got_next;
    value_t                 got_value_reg, got_value_next;
    cnt_t                   seen_reg, seen_next;
    idx_t                   cmp_idx_reg, cmp_idx_next;

    // latched request
    logic [OP_W-1:0]        op_reg;
    value_t                 val_reg;
    logic [RANK_W-1:0]      rank_reg;

    // result register
    logic                   ok_reg, ok_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    value_t                 found_reg, found_next;
    cnt_t                   cnt_out_reg;
    logic                   empty_reg;

    logic                   in_xfer;
    logic                   commit;
    cnt_t                   slots;
    logic [MAX_ENTRIES-1:0] in_use_mask;
    logic                   ram_we, ram_re;
    idx_t                   ram_raddr;
    value_t                 ram_rdata;
    logic                   cmp_valid;

    // slots in use: capacity saturated at the table size
    assign slots = (cap_reg > CAP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cap_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            in_use_mask[i] = (CNT_W'(i) < slots);
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // result may be loaded when the output register is empty or draining this cycle
    assign commit   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign ram_re    = (state_reg == S_SCAN) && (issue_cnt_reg < slots);
    assign ram_raddr = issue_cnt_reg[IDX_W-1:0];
    assign cmp_valid = valid_reg[cmp_idx_reg];

    fcst_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (VALUE_WIDTH)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_act_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        got_next       = got_reg;
        got_value_next = got_value_reg;
        seen_next      = seen_reg;
        ok_next        = 1'b0;
        status_next    = ST_DONE;
        found_next     = '0;
        ram_we         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next     = S_SCAN;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    got_next       = 1'b0;
                    seen_next      = '0;
                end
            end
            S_SCAN:
            begin
                // issue side: one slot read per cycle
                if (ram_re)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    cmp_act_next   = 1'b1;
                    cmp_idx_next   = ram_raddr;
                end
                // compare side: memory data of the slot read last cycle
                if (cmp_act_reg)
                begin
                    if (cmp_valid)
                    begin
                        if (!hit_reg && ram_rdata == val_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = cmp_idx_reg;
                        end
                        if (!got_reg && seen_reg == CNT_W'(rank_reg))
                        begin
                            got_next       = 1'b1;
                            got_value_next = ram_rdata;
                        end
                        seen_next = seen_reg + 1'b1;
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
                if (!ram_re && !cmp_act_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            // full wins over duplicate
                            if (count_reg >= slots || !free_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (hit_reg)
                            begin
                                status_next = ST_DUP;
                            end
                            else
                            begin
                                ok_next                  = 1'b1;
                                ram_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                count_next               = count_reg + 1'b1;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (hit_reg)
                            begin
                                ok_next                 = 1'b1;
                                valid_next[hit_idx_reg] = 1'b0;
                                count_next              = count_reg - 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            ok_next     = hit_reg;
                            status_next = hit_reg ? ST_DONE : ST_NOT_FOUND;
                        end
                        default:
                        begin
                            if (CNT_W'(rank_reg) >= count_reg)
                            begin
                                status_next = ST_RANK;
                            end
                            else if (got_reg)
                            begin
                                ok_next    = 1'b1;
                                found_next = got_value_reg;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a capacity write starts a new, empty table
        if (capacity_wr_en)
        begin
            valid_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            cmp_act_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            got_reg       <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_act_reg   <= cmp_act_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            got_reg       <= got_next;
            seen_reg      <= seen_next;
            if (capacity_wr_en)
            begin
                cap_reg <= capacity;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        got_value_reg <= got_value_next;
        if (in_xfer)
        begin
            op_reg   <= opcode;
            val_reg  <= item_value;
            rank_reg <= slot_rank;
        end
        if (commit)
        begin
            ok_reg      <= ok_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            cnt_out_reg <= count_next;
            empty_reg   <= (count_next == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign item_count  = cnt_out_reg;
    assign is_empty    = empty_reg;

`ifndef SYNTHESIS
    // running count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count differs from valid bits");

    // no entry is ever valid outside the slots in use
    a_valid_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & ~in_use_mask) == '0)
        else $error("valid entry beyond capacity");

    // an insert only writes a free slot
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[free_idx_reg])
        else $error("insert overwrites a valid slot");

    // compare stage only runs inside a scan
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_act_reg |-> (state_reg == S_SCAN))
        else $error("compare stage active outside scan");

    // scan never reads past the slots in use
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= slots))
        else $error("scan index beyond capacity");
`endif

endmodule
